@@ sv/wsat_pkg.sv @@
`timescale 1ns / 1ps

package wsat_pkg;

  // Distribution-system code, frame control bits 9:8
  localparam logic [1:0] DS_NONE    = 2'b00;
  localparam logic [1:0] DS_TO_DS   = 2'b01;
  localparam logic [1:0] DS_FROM_DS = 2'b10;
  localparam logic [1:0] DS_WDS     = 2'b11;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned CNT16_W = 16;
  localparam int unsigned RSSI_W = 8;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned USED_W = 9;

  typedef enum logic [1:0] {
    ST_IGNORED  = 2'd0,
    ST_UPDATED  = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    B_IDLE,
    B_SEARCH
  } back_state_e;

  // Classified frame, front to back
  typedef struct packed {
    logic              ignore;
    logic [ADDR_W-1:0] src_addr;
    logic [RSSI_W-1:0] strength;
  } job_t;

  typedef struct packed {
    status_e              status;
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT16_W-1:0]   hit_count;
    logic [USED_W-1:0]    entries_used;
  } res_t;

endpackage

@@ sv/wsat_if.sv @@
`timescale 1ns / 1ps

interface wsat_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        frame_control;
  logic [47:0]        second_address;
  logic [47:0]        third_address;
  logic signed [7:0]  signal_strength;

  modport source (
    output valid, frame_control, second_address, third_address, signal_strength,
    input  ready
  );
  modport sink (
    input  valid, frame_control, second_address, third_address, signal_strength,
    output ready
  );
endinterface

interface wsat_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  entry_index;
  logic [15:0] hit_count;
  logic [8:0]  entries_used;

  modport source (
    output valid, status, entry_index, hit_count, entries_used,
    input  ready
  );
  modport sink (
    input  valid, status, entry_index, hit_count, entries_used,
    output ready
  );
endinterface

@@ sv/wireless_source_address_tracker.sv @@
`timescale 1ns / 1ps

// Source address learning table for received 802.11 headers.
// frame_i: one transfer per header (frame control, address 2, address 3,
//   signal strength). DS code 1 learns address 3, codes 0 and 2 learn
//   address 2, code 3 is reported as ignored without touching the table.
// result_o: exactly one transfer per header, in arrival order: status,
//   slot, count after the frame, and the number of learned entries.
// Front: classifies the header and pushes it into a two-entry job queue,
//   so headers keep being taken while the back walks the table or while
//   a result waits in the output register.
// Back: walks the learned entries in order, one memory read per cycle,
//   compare in the cycle after each read. First match wins.
// Result: registered. A hit ends the walk at its slot, a miss reads every
//   learned entry first, and an ignored header skips the walk.
// The back finishes one header before it takes the next; each walk is
//   bound by the single read port of the table.
// Reset: the fill level goes to zero; table contents are not cleared, no
//   entry is read before it is written. No clearing pass is needed.
// Receiver stall: the result register holds; the back waits, the queue
//   fills, and then frame_i.ready drops.
module wireless_source_address_tracker #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsat_in_if.sink    frame_i,
  wsat_out_if.source result_o
);

  logic           push_valid, push_ready;
  wsat_pkg::job_t push_job;
  logic           pop_valid, pop;
  wsat_pkg::job_t pop_job;

  wsat_front u_front (
    .frm_i        (frame_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  wsat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_i        (pop)
  );

  wsat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .res_o       (result_o)
  );

endmodule

@@ sv/wsat_front.sv @@
`timescale 1ns / 1ps

// Picks the source address from the DS code and pushes a job.
module wsat_front (
  wsat_in_if.sink       frm_i,
  output logic          push_valid_o,
  output wsat_pkg::job_t push_job_o,
  input  logic          push_ready_i
);

  logic [1:0] ds;

  always_comb begin
    ds = frm_i.frame_control[9:8];
    push_job_o.ignore   = (ds == wsat_pkg::DS_WDS);
    push_job_o.strength = frm_i.signal_strength;
    case (ds)
      wsat_pkg::DS_TO_DS: push_job_o.src_addr = frm_i.third_address;
      default:            push_job_o.src_addr = frm_i.second_address;
    endcase
  end

  assign push_valid_o = frm_i.valid;
  assign frm_i.ready  = push_ready_i;

endmodule

@@ sv/wsat_queue.sv @@
`timescale 1ns / 1ps

// Two-entry job queue between front and back.
module wsat_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  wsat_pkg::job_t push_job_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output wsat_pkg::job_t pop_job_o,
  input  logic           pop_i
);

  wsat_pkg::job_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ sv/wsat_back.sv @@
`timescale 1ns / 1ps

// Table walk: one memory read per cycle, compare in the cycle after each read,
// then update, append or drop, and load the result register; ignored jobs skip the walk.
module wsat_back #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  wsat_pkg::job_t job_i,
  output logic           pop_o,
  wsat_out_if.source     res_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_LVL = CNT_W'(TABLE_ENTRIES);

  logic [wsat_pkg::ADDR_W-1:0]  addr_mem [TABLE_ENTRIES];
  logic [wsat_pkg::CNT16_W-1:0] hit_mem  [TABLE_ENTRIES];
  logic [wsat_pkg::RSSI_W-1:0]  str_mem  [TABLE_ENTRIES];

  wsat_pkg::back_state_e state_q, state_d;
  wsat_pkg::job_t        job_q;
  wsat_pkg::res_t        out_q, res_d;
  logic                  out_vld_q, out_vld_d;

  logic [CNT_W-1:0]             rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]             cmp_idx_q;
  logic [wsat_pkg::ADDR_W-1:0]  addr_rd_q;
  logic [wsat_pkg::CNT16_W-1:0] hit_rd_q;

  logic in_search, hit, miss, decide, out_free, issue, full, load_job, emit;
  logic wr_addr_en, wr_cnt_en;
  logic [IDX_W-1:0]             wr_idx;
  logic [wsat_pkg::CNT16_W-1:0] wr_cnt;

  always_comb begin
    in_search = (state_q == wsat_pkg::B_SEARCH);
    out_free  = !out_vld_q || res_o.ready;
    hit       = in_search && cmp_vld_q && (addr_rd_q == job_q.src_addr);
    miss      = in_search && !cmp_vld_q && (rd_idx_q >= fill_q);
    decide    = hit || miss;
    issue     = in_search && !decide && (rd_idx_q < fill_q);
    full      = (fill_q == FULL_LVL);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsat_pkg::B_IDLE: begin
        if (job_valid_i && !job_i.ignore) begin
          state_d = wsat_pkg::B_SEARCH;
        end
      end
      wsat_pkg::B_SEARCH: begin
        if (decide && out_free) begin
          state_d = wsat_pkg::B_IDLE;
        end
      end
      default: state_d = wsat_pkg::B_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    pop_o      = 1'b0;
    load_job   = 1'b0;
    emit       = 1'b0;
    wr_addr_en = 1'b0;
    wr_cnt_en  = 1'b0;
    wr_idx     = cmp_idx_q;
    wr_cnt     = wsat_pkg::CNT16_W'(hit_rd_q + 16'd1);
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    cmp_vld_d  = 1'b0;
    res_d.status       = wsat_pkg::ST_IGNORED;
    res_d.entry_index  = '0;
    res_d.hit_count    = '0;
    res_d.entries_used = wsat_pkg::USED_W'(fill_q);
    unique case (state_q)
      wsat_pkg::B_IDLE: begin
        if (job_valid_i) begin
          if (job_i.ignore) begin
            if (out_free) begin
              pop_o = 1'b1;
              emit  = 1'b1;
            end
          end else begin
            pop_o    = 1'b1;
            load_job = 1'b1;
            rd_idx_d = '0;
          end
        end
      end
      wsat_pkg::B_SEARCH: begin
        if (issue) begin
          cmp_vld_d = 1'b1;
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end else if (decide && !out_free) begin
          // hold the compare stage until the result register frees up
          cmp_vld_d = cmp_vld_q;
        end
        if (decide && out_free) begin
          emit = 1'b1;
          if (hit) begin
            wr_cnt_en         = 1'b1;
            res_d.status      = wsat_pkg::ST_UPDATED;
            res_d.entry_index = wsat_pkg::IDX_OUT_W'(cmp_idx_q);
            res_d.hit_count   = wr_cnt;
          end else if (full) begin
            res_d.status = wsat_pkg::ST_FULL;
          end else begin
            wr_idx             = fill_q[IDX_W-1:0];
            wr_cnt             = 16'd1;
            wr_addr_en         = 1'b1;
            wr_cnt_en          = 1'b1;
            fill_d             = fill_q + CNT_W'(1);
            res_d.status       = wsat_pkg::ST_INSERTED;
            res_d.entry_index  = wsat_pkg::IDX_OUT_W'(fill_q);
            res_d.hit_count    = 16'd1;
            res_d.entries_used = wsat_pkg::USED_W'(fill_d);
          end
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wsat_pkg::B_IDLE;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      job_q <= job_i;
    end
    if (emit) begin
      out_q <= res_d;
    end
    if (issue) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
    end
  end

  // table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_addr_en) begin
      addr_mem[wr_idx] <= job_q.src_addr;
    end
    if (wr_cnt_en) begin
      hit_mem[wr_idx] <= wr_cnt;
      str_mem[wr_idx] <= job_q.strength;
    end
    if (issue) begin
      addr_rd_q <= addr_mem[rd_idx_q[IDX_W-1:0]];
      hit_rd_q  <= hit_mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_q.status;
  assign res_o.entry_index  = out_q.entry_index;
  assign res_o.hit_count    = out_q.hit_count;
  assign res_o.entries_used = out_q.entries_used;

endmodule

@@ sv/wsat_checker.sv @@
`timescale 1ns / 1ps

module wsat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [7:0]  entry_index_i,
  input logic [15:0] hit_count_i,
  input logic [8:0]  entries_used_i
);

  // stalled result must hold its status, count and fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(hit_count_i) && $stable(entries_used_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == wsat_pkg::ST_IGNORED || status_i == wsat_pkg::ST_FULL)
      |-> entry_index_i == 8'd0 && hit_count_i == 16'd0)
    else $error("ignored or dropped frame reports a slot or count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == wsat_pkg::ST_INSERTED |-> hit_count_i == 16'd1)
    else $error("new entry without count one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == wsat_pkg::ST_INSERTED |-> entries_used_i != 9'd0)
    else $error("insert left the table empty");

endmodule

bind wireless_source_address_tracker wsat_checker u_wsat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .status_i       (result_o.status),
  .entry_index_i  (result_o.entry_index),
  .hit_count_i    (result_o.hit_count),
  .entries_used_i (result_o.entries_used)
);
